@@ sv/skl_pkg.sv @@
// Shared types and constants for the sorted key list.
`timescale 1ns / 1ps

package skl_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths on the stream ports
  localparam int OP_W     = 3;
  localparam int KEY_IN_W = 32;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD          = 3'd0,
    OP_REMOVE_FIRST = 3'd1,
    OP_REMOVE_LAST  = 3'd2,
    OP_REMOVE_MATCH = 3'd3,
    OP_READ_INDEX   = 3'd4,
    OP_READ_FIRST   = 3'd5,
    OP_READ_LAST    = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  // What every cell does with its entry in a given cycle
  typedef enum logic [1:0] {
    MODE_HOLD        = 2'd0,
    MODE_INSERT      = 2'd1,
    MODE_SHIFT_ALL   = 2'd2,
    MODE_SHIFT_MATCH = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  cmp_signed;
  } cell_ctrl_t;

endpackage

@@ sv/skl_cell.sv @@
// One storage cell of the sorted key list: holds a key, compares it, shifts it.
`timescale 1ns / 1ps

module skl_cell #(
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 5,
  parameter int SEL_W     = 5,
  parameter int POS       = 0
) (
  input  logic                   clk,
  input  skl_pkg::cell_ctrl_t    ctrl,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [CNT_W-1:0]       count,
  input  logic [SEL_W-1:0]       sel,
  input  logic [KEY_WIDTH-1:0]   left_key,
  input  logic                   left_gt,
  input  logic                   left_eq,
  input  logic [KEY_WIDTH-1:0]   right_key,
  output logic [KEY_WIDTH-1:0]   entry,
  output logic                   gt,
  output logic                   eq,
  output logic [KEY_WIDTH-1:0]   rd
);

  logic                 occupied;
  logic                 gt_here;
  logic                 eq_here;
  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] ord_entry;
  logic [KEY_WIDTH-1:0] ord_key;
  logic [KEY_WIDTH-1:0] entry_next;

  assign occupied  = CNT_W'(POS) < count;
  // Flipping the sign bit maps two's complement order onto unsigned order
  assign flip      = {ctrl.cmp_signed, {(KEY_WIDTH-1){1'b0}}};
  assign ord_entry = entry ^ flip;
  assign ord_key   = key ^ flip;
  assign gt_here   = occupied && (ord_entry > ord_key);
  assign eq_here   = occupied && (entry == key);
  // Carry along the row: this cell or one to its left is above / equal to the key
  assign gt        = left_gt || gt_here;
  assign eq        = left_eq || eq_here;
  assign rd        = (SEL_W'(POS) == sel) ? entry : '0;

  always_comb begin
    entry_next = entry;
    unique case (ctrl.mode)
      skl_pkg::MODE_HOLD: begin
        entry_next = entry;
      end
      skl_pkg::MODE_INSERT: begin
        // Cells past the slot take the left neighbor; the slot takes the key
        if (left_gt) begin
          entry_next = left_key;
        end else if (gt_here || !occupied) begin
          entry_next = key;
        end
      end
      skl_pkg::MODE_SHIFT_ALL: begin
        entry_next = right_key;
      end
      skl_pkg::MODE_SHIFT_MATCH: begin
        // Close the gap from the first equal key onward
        if (eq) begin
          entry_next = right_key;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ sv/sorted_key_list.sv @@
// A result is registered and shows on the master side in the cycle after its request
// is taken. Throughput: one request per cycle, held back only while a finished result
// waits on m_tready; adds and front or match removals update the whole row at once.
// Reset clears the key count, the ordering mode and the output valid; cell
// contents are not cleared and are never read before being written.
// Top level: sorted key list built from a row of shifting cells.
`timescale 1ns / 1ps

module sorted_key_list #(
  parameter int DEPTH     = skl_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = skl_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // key [31:0], index [35:32], zero [39:36]
  input  logic [2:0]  s_tuser,   // operation [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // key_out [31:0], status [34:32], count [39:35]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SEL_W = (CNT_W > skl_pkg::IDX_W) ? CNT_W : skl_pkg::IDX_W;

  logic [CNT_W-1:0]     occupancy;
  logic [CNT_W-1:0]     occupancy_next;
  logic                 cmp_signed;

  skl_pkg::op_t         op;
  logic [31:0]          key_in;
  logic [skl_pkg::IDX_W-1:0] idx;
  logic [KEY_WIDTH+31:0] key_wide;
  logic [KEY_WIDTH-1:0] key_kw;
  logic                 in_fire;
  logic                 full;
  logic                 empty;
  logic                 found;
  logic [SEL_W-1:0]     last_pos;
  logic [SEL_W-1:0]     sel;
  skl_pkg::mode_t       mode;
  skl_pkg::status_t     status;
  skl_pkg::cell_ctrl_t  ctrl;
  logic [KEY_WIDTH-1:0] result_kw;
  logic [KEY_WIDTH+31:0] result_wide;
  logic [KEY_WIDTH-1:0] rd_data;

  logic [KEY_WIDTH-1:0] entry_q [DEPTH];
  logic [KEY_WIDTH-1:0] rd_q    [DEPTH];
  logic [DEPTH-1:0]     gt_v;
  logic [DEPTH-1:0]     eq_v;

  assign op       = skl_pkg::op_t'(s_tuser);
  assign key_in   = s_tdata[31:0];
  assign idx      = s_tdata[35:32];
  assign key_wide = {KEY_WIDTH'(0), key_in};
  assign key_kw   = key_wide[KEY_WIDTH-1:0];

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign full     = occupancy == CNT_W'(DEPTH);
  assign empty    = occupancy == '0;
  assign found    = eq_v[DEPTH-1];
  assign last_pos = SEL_W'(occupancy) - SEL_W'(1);

  always_comb begin
    mode           = skl_pkg::MODE_HOLD;
    sel            = '0;
    status         = skl_pkg::ST_OK;
    result_kw      = '0;
    occupancy_next = occupancy;
    unique case (op)
      skl_pkg::OP_ADD: begin
        if (full) begin
          status = skl_pkg::ST_FULL;
        end else begin
          mode           = skl_pkg::MODE_INSERT;
          occupancy_next = occupancy + CNT_W'(1);
        end
      end
      skl_pkg::OP_REMOVE_FIRST: begin
        if (empty) begin
          status = skl_pkg::ST_EMPTY;
        end else begin
          mode           = skl_pkg::MODE_SHIFT_ALL;
          result_kw      = rd_data;
          occupancy_next = occupancy - CNT_W'(1);
        end
      end
      skl_pkg::OP_REMOVE_LAST: begin
        sel = last_pos;
        if (empty) begin
          status = skl_pkg::ST_EMPTY;
        end else begin
          result_kw      = rd_data;
          occupancy_next = occupancy - CNT_W'(1);
        end
      end
      skl_pkg::OP_REMOVE_MATCH: begin
        if (!found) begin
          status = skl_pkg::ST_NOT_FOUND;
        end else begin
          mode           = skl_pkg::MODE_SHIFT_MATCH;
          result_kw      = key_kw;
          occupancy_next = occupancy - CNT_W'(1);
        end
      end
      skl_pkg::OP_READ_INDEX: begin
        sel = SEL_W'(idx);
        if (SEL_W'(idx) >= SEL_W'(occupancy)) begin
          status = skl_pkg::ST_BAD_INDEX;
        end else begin
          result_kw = rd_data;
        end
      end
      skl_pkg::OP_READ_FIRST: begin
        if (empty) begin
          status = skl_pkg::ST_EMPTY;
        end else begin
          result_kw = rd_data;
        end
      end
      skl_pkg::OP_READ_LAST: begin
        sel = last_pos;
        if (empty) begin
          status = skl_pkg::ST_EMPTY;
        end else begin
          result_kw = rd_data;
        end
      end
      default: begin
        // unused code: no change, empty result
      end
    endcase
  end

  // Hold every cell unless a request is taken this cycle
  assign ctrl.mode       = in_fire ? mode : skl_pkg::MODE_HOLD;
  assign ctrl.cmp_signed = cmp_signed;

  assign result_wide = {32'(0), result_kw};

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | rd_q[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    logic                 left_gt;
    logic                 left_eq;
    logic [KEY_WIDTH-1:0] right_key;

    if (g == 0) begin : g_first
      assign left_key = key_kw;
      assign left_gt  = 1'b0;
      assign left_eq  = 1'b0;
    end else begin : g_mid
      assign left_key = entry_q[g-1];
      assign left_gt  = gt_v[g-1];
      assign left_eq  = eq_v[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_key = entry_q[g];
    end else begin : g_body
      assign right_key = entry_q[g+1];
    end

    skl_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .SEL_W     (SEL_W),
      .POS       (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key_kw),
      .count     (occupancy),
      .sel       (sel),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .left_eq   (left_eq),
      .right_key (right_key),
      .entry     (entry_q[g]),
      .gt        (gt_v[g]),
      .eq        (eq_v[g]),
      .rd        (rd_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy  <= '0;
      cmp_signed <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cmp_signed <= cfg_data;
      end
      if (in_fire) begin
        occupancy <= occupancy_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {skl_pkg::COUNT_W'(occupancy_next), status, result_wide[31:0]};
    end
  end

endmodule

@@ sv/skl_checker.sv @@
// Port checks for the sorted key list and their binding to the top level.
`timescale 1ns / 1ps

module skl_checker #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Every taken request shows a result in the next cycle
  a_answer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("request taken without a result");

  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[34:32] != skl_pkg::ST_OK) |-> m_tdata[31:0] == 32'd0)
    else $error("key returned with an error status");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[34:32] == skl_pkg::ST_FULL)
      |-> m_tdata[39:35] == skl_pkg::COUNT_W'(DEPTH))
    else $error("full reported below capacity");

endmodule

bind sorted_key_list skl_checker #(
  .DEPTH (DEPTH)
) u_skl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
